// ----- sv/fixed_partition_fit_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Fixed partition fit allocator assertion macros
// Shared concurrent assertion wrappers. Simulation builds get the checks;
// synthesis builds get empty bodies.
// ---------------------------------------------------------------------------
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define FPFA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FPFA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define FPFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- sv/fpfa_pkg.sv -----
// ---------------------------------------------------------------------------
// Fixed partition fit allocator package
// Codes and controller/datapath interface types.
// ---------------------------------------------------------------------------
package fpfa_pkg;

  localparam logic       OP_LOAD          = 1'b0;
  localparam logic       OP_ALLOC         = 1'b1;

  localparam logic [1:0] POLICY_FIRST     = 2'd0;
  localparam logic [1:0] POLICY_BEST      = 2'd1;
  localparam logic [1:0] POLICY_WORST     = 2'd2;

  localparam logic [1:0] STATUS_LOADED    = 2'd0;
  localparam logic [1:0] STATUS_ALLOCATED = 2'd1;
  localparam logic [1:0] STATUS_NONE      = 2'd2;

  localparam logic       REG_FIT_POLICY   = 1'b0;
  localparam logic       REG_BLOCKS_USED  = 1'b1;

  localparam logic [4:0] BLOCKS_USED_RST  = 5'd16;

  typedef struct packed {
    logic capture;
    logic scan_rd;
    logic load_wr;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_alloc;
    logic scan_empty;
    logic scan_last;
  } ctrl_sts_t;

endpackage

// ----- sv/fpfa_datapath.sv -----
// ---------------------------------------------------------------------------
// Fixed partition fit allocator datapath
// Free space table, scan counter, fit comparison and result registers.
// ---------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_macros.svh"

module fpfa_datapath import fpfa_pkg::*; #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  input  logic        in_operation,
  input  logic [3:0]  in_block_number,
  input  logic [15:0] in_size,
  input  logic [1:0]  fit_policy,
  input  logic [4:0]  blocks_in_use,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_chosen_block,
  output logic [15:0] out_space_left
);

  localparam int CW = $clog2(NUM_BLOCKS + 1);
  localparam int IW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int LW = (CW > 5) ? CW : 5;
  localparam int LB = (CW > 4) ? CW : 4;

  logic [SIZE_WIDTH-1:0] mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_r;

  logic                  op_r;
  logic [3:0]            blk_r;
  logic [SIZE_WIDTH-1:0] req_r;
  logic [CW-1:0]         cnt_r;
  logic [SIZE_WIDTH-1:0] rd_data_r;
  logic [IW-1:0]         rd_idx_r;
  logic                  rd_vld_r;
  logic                  found_r;
  logic [IW-1:0]         pick_r;
  logic [SIZE_WIDTH-1:0] best_r;
  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [3:0]            out_block_r;
  logic [15:0]           out_space_r;

  logic [LW-1:0]         limit;
  logic [LW-1:0]         biu_w;
  logic [LW-1:0]         nb_w;
  logic [IW-1:0]         idx;
  logic [LB-1:0]         blk_ext;
  logic                  blk_in_range;
  logic                  take;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [SIZE_WIDTH-1:0] wr_data;
  logic [SIZE_WIDTH-1:0] alloc_left;

  assign biu_w        = LW'(blocks_in_use);
  assign nb_w         = LW'(NUM_BLOCKS);
  assign limit        = (biu_w > nb_w) ? nb_w : biu_w;
  assign idx          = cnt_r[IW-1:0];
  assign blk_ext      = LB'(blk_r);
  assign blk_in_range = blk_ext < LB'(NUM_BLOCKS);
  assign alloc_left   = best_r - req_r;

  assign sts.in_alloc   = (in_operation == OP_ALLOC);
  assign sts.scan_empty = (limit == '0);
  assign sts.scan_last  = ((LW'(cnt_r) + LW'(1)) == limit);

  always_comb begin
    take = 1'b0;
    if (rd_vld_r && (rd_data_r >= req_r)) begin
      if (!found_r) begin
        take = 1'b1;
      end else if (fit_policy == POLICY_BEST) begin
        take = (rd_data_r < best_r);
      end else if (fit_policy == POLICY_WORST) begin
        take = (rd_data_r > best_r);
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = pick_r;
    wr_data = alloc_left;
    if (cmd.load_wr) begin
      wr_en   = blk_in_range;
      wr_addr = blk_ext[IW-1:0];
      wr_data = req_r;
    end else if (cmd.finish) begin
      wr_en   = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.scan_rd) begin
      rd_data_r <= vld_r[idx] ? mem[idx] : '0;
      rd_idx_r  <= idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_operation;
      blk_r <= in_block_number;
      req_r <= SIZE_WIDTH'(in_size);
    end
    if (take) begin
      pick_r <= rd_idx_r;
      best_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.capture) begin
        cnt_r   <= '0;
        found_r <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (take) begin
          found_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.load_wr || cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr) begin
      out_status_r <= STATUS_LOADED;
      out_block_r  <= blk_r;
      out_space_r  <= blk_in_range ? 16'(req_r) : '0;
    end else if (cmd.finish) begin
      if (found_r) begin
        out_status_r <= STATUS_ALLOCATED;
        out_block_r  <= 4'(pick_r);
        out_space_r  <= 16'(alloc_left);
      end else begin
        out_status_r <= STATUS_NONE;
        out_block_r  <= '0;
        out_space_r  <= '0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_chosen_block = out_block_r;
  assign out_space_left   = out_space_r;

  `FPFA_ASSERT_NEXT(a_rd_follows_issue, clk, rst_n, cmd.scan_rd, rd_vld_r, "Read data did not follow a scan read.")
  `FPFA_ASSERT_IMPLY(a_pick_fits, clk, rst_n, cmd.finish && found_r, best_r >= req_r, "Chosen block is smaller than the request.")
  `FPFA_ASSERT_IMPLY(a_op_matches, clk, rst_n, cmd.finish, op_r == OP_ALLOC, "Allocation finished for a load transaction.")

endmodule

// ----- sv/fpfa_ctrl.sv -----
// ---------------------------------------------------------------------------
// Fixed partition fit allocator controller
// Sequences load and allocate transactions over the datapath.
// ---------------------------------------------------------------------------
`include "fixed_partition_fit_allocator_macros.svh"

module fpfa_ctrl import fpfa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd,
  output logic      busy
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (!sts.in_alloc) begin
            state_nxt = ST_LOAD;
          end else if (sts.scan_empty) begin
            state_nxt = ST_FINISH;
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  `FPFA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "Controller stayed idle after a transaction was accepted.")
  `FPFA_ASSERT_NEXT(a_idle_after_done, clk, rst_n, cmd.finish || cmd.load_wr, !busy, "Controller did not return to idle.")
  `FPFA_ASSERT_NEXT(a_drain_after_scan, clk, rst_n, state_r == ST_SCAN && sts.scan_last, state_r == ST_DRAIN, "Scan did not end after the last block.")

endmodule

// ----- sv/fixed_partition_fit_allocator.sv -----
// ---------------------------------------------------------------------------
// Fixed partition fit allocator
// Keeps the free space of a set of memory blocks and serves load and
// first, best or worst fit allocate transactions.
// ---------------------------------------------------------------------------
// A transaction is accepted when start is high and busy is low. An allocate
// scans min(blocks_in_use, NUM_BLOCKS) blocks, then a drain and a finish
// step, because the free space table has one read port and the scan reads
// one block per cycle; an allocate that scans no block goes straight to the
// finish step. Each result appears for exactly one cycle with out_valid high,
// in the first cycle in which busy is low again, and it cannot be held off
// by the receiver.
// The table holds zero for every block after reset without a clearing pass.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
  parameter int NUM_BLOCKS = 16,
  parameter int SIZE_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [3:0]  in_block_number,
  input  logic [15:0] in_size,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_chosen_block,
  output logic [15:0] out_space_left,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0] cfg_fit_policy_r;
  logic [4:0] cfg_blocks_in_use_r;
  logic       cfg_wr;
  ctrl_cmd_t  cmd;
  ctrl_sts_t  sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_fit_policy_r    <= POLICY_FIRST;
      cfg_blocks_in_use_r <= BLOCKS_USED_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FIT_POLICY) begin
        cfg_fit_policy_r <= pwdata[1:0];
      end else begin
        cfg_blocks_in_use_r <= pwdata[4:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_BLOCKS_USED) ? {27'd0, cfg_blocks_in_use_r}
                                                : {30'd0, cfg_fit_policy_r};

  fpfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  fpfa_datapath #(
    .NUM_BLOCKS (NUM_BLOCKS),
    .SIZE_WIDTH (SIZE_WIDTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_operation     (in_operation),
    .in_block_number  (in_block_number),
    .in_size          (in_size),
    .fit_policy       (cfg_fit_policy_r),
    .blocks_in_use    (cfg_blocks_in_use_r),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_chosen_block (out_chosen_block),
    .out_space_left   (out_space_left)
  );

endmodule

// ----- sim/fixed_partition_fit_allocator_test.sv -----
// ---------------------------------------------------------------------------
// Fixed partition fit allocator testbench
// Drives load and allocate transactions in random bursts under every fit
// policy and several block counts, predicts each result from a private copy
// of the free space table, and compares every result field by field. Each
// register write is read back over the same port.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module fixed_partition_fit_allocator_test import fpfa_pkg::*;;

  localparam logic [1:0] POLICY_UNUSED = 2'd3;
  localparam int         TABLE_DEPTH   = 16;
  localparam int         CYCLE_LIMIT   = 500000;
  localparam int         DRAIN_CYCLES  = 25;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  block;
    logic [15:0] left;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [15:0]   free_space [TABLE_DEPTH];
    logic [1:0]    policy;
    logic [4:0]    blocks_used;
    alloc_result_t pending [$];
    int            errors;

    function new();
      foreach (free_space[i]) free_space[i] = '0;
      policy      = POLICY_FIRST;
      blocks_used = BLOCKS_USED_RST;
      errors      = 0;
    endfunction

    function void set_register(logic reg_sel, logic [31:0] value);
      if (reg_sel == REG_FIT_POLICY) begin
        policy = value[1:0];
      end else begin
        blocks_used = value[4:0];
      end
    endfunction

    function void note_request(logic op, logic [3:0] block, logic [15:0] size);
      int            limit;
      int            pick;
      bit            found;
      alloc_result_t res;
      found = 1'b0;
      pick  = 0;
      if (op == OP_LOAD) begin
        free_space[block] = size;
        res = '{STATUS_LOADED, block, size};
      end else begin
        limit = (blocks_used > TABLE_DEPTH) ? TABLE_DEPTH : int'(blocks_used);
        for (int j = 0; j < limit; j++) begin
          if (free_space[j] >= size) begin
            if (!found) begin
              found = 1'b1;
              pick  = j;
              if (policy != POLICY_BEST && policy != POLICY_WORST) break;
            end else if (policy == POLICY_BEST && free_space[j] < free_space[pick]) begin
              pick = j;
            end else if (policy == POLICY_WORST && free_space[j] > free_space[pick]) begin
              pick = j;
            end
          end
        end
        if (found) begin
          free_space[pick] = free_space[pick] - size;
          res = '{STATUS_ALLOCATED, pick[3:0], free_space[pick]};
        end else begin
          res = '{STATUS_NONE, 4'd0, 16'd0};
        end
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic [1:0] status, logic [3:0] block, logic [15:0] left);
      alloc_result_t exp;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: status %0d block %0d space %0d",
                 $time, status, block, left);
        return;
      end
      exp = pending.pop_front();
      if (status !== exp.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, exp.status, status);
      end
      if (block !== exp.block) begin
        errors++;
        $display("%0t: chosen block expected %0d actual %0d", $time, exp.block, block);
      end
      if (left !== exp.left) begin
        errors++;
        $display("%0t: space left expected %0d actual %0d", $time, exp.left, left);
      end
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        start           = 1'b0;
  logic        busy;
  logic        in_operation    = OP_LOAD;
  logic [3:0]  in_block_number = '0;
  logic [15:0] in_size         = '0;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [3:0]  out_chosen_block;
  logic [15:0] out_space_left;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = '0;
  logic [31:0] pwdata          = '0;
  logic [31:0] prdata;
  logic        pready;

  alloc_scoreboard sb;
  int unsigned     cycles = 0;

  fixed_partition_fit_allocator i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_block_number  (in_block_number),
    .in_size          (in_size),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_chosen_block (out_chosen_block),
    .out_space_left   (out_space_left),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL fixed_partition_fit_allocator");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      sb.check_result(out_status, out_chosen_block, out_space_left);
    end
  end

  task automatic send_transaction(logic op, logic [3:0] block, logic [15:0] size);
    start           <= 1'b1;
    in_operation    <= op;
    in_block_number <= block;
    in_size         <= size;
    do @(posedge clk); while (busy);
    sb.note_request(op, block, size);
  endtask

  task automatic write_register(logic reg_sel, logic [31:0] value);
    logic [31:0] mask;
    mask    = (reg_sel == REG_FIT_POLICY) ? 32'h3 : 32'h1f;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_register(reg_sel, value);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (value & mask)) begin
      sb.errors++;
      $display("%0t: register %0d read expected %0d actual %0d",
               $time, reg_sel, value & mask, prdata & mask);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic reconfigure(logic [1:0] policy, logic [4:0] used);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_register(REG_FIT_POLICY, {30'd0, policy});
    write_register(REG_BLOCKS_USED, {27'd0, used});
    @(posedge clk);
  endtask

  task automatic random_transactions(int unsigned count);
    int unsigned burst;
    int unsigned gap;
    logic        op;
    logic [3:0]  block;
    logic [15:0] size;
    burst = $urandom_range(1, 20);
    for (int unsigned n = 0; n < count; n++) begin
      op    = ($urandom_range(0, 99) < 40) ? OP_LOAD : OP_ALLOC;
      block = 4'($urandom_range(0, 15));
      if (op == OP_LOAD) begin
        case ($urandom_range(0, 5))
          0:       size = 16'd0;
          1:       size = 16'hffff;
          2:       size = 16'($urandom);
          3, 4:    size = 16'($urandom_range(1, 8) * 100);
          default: size = 16'($urandom_range(0, 1023));
        endcase
      end else begin
        case ($urandom_range(0, 5))
          0:       size = 16'd0;
          1:       size = sb.free_space[$urandom_range(0, TABLE_DEPTH - 1)];
          2:       size = 16'($urandom);
          3, 4:    size = 16'($urandom_range(1, 300));
          default: size = 16'hffff;
        endcase
      end
      send_transaction(op, block, size);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        gap   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
        if (gap != 0) begin
          start <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  endtask

  initial begin
    logic [1:0] policies [12];
    logic [4:0] counts [12];
    sb = new();
    policies = '{POLICY_BEST, POLICY_WORST, POLICY_UNUSED, POLICY_FIRST, POLICY_BEST,
                 POLICY_WORST, POLICY_BEST, POLICY_FIRST, POLICY_WORST, POLICY_BEST,
                 POLICY_FIRST, POLICY_WORST};
    counts   = '{5'd16, 5'd16, 5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd5, 5'd12,
                 5'd16, 5'd3};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table under the reset settings, then a few loads and allocates.
    send_transaction(OP_ALLOC, 4'd9, 16'd0);
    send_transaction(OP_ALLOC, 4'd0, 16'd1);
    send_transaction(OP_ALLOC, 4'd15, 16'hffff);
    send_transaction(OP_LOAD, 4'd0, 16'hffff);
    send_transaction(OP_LOAD, 4'd15, 16'h8000);
    send_transaction(OP_LOAD, 4'd5, 16'h5555);
    send_transaction(OP_LOAD, 4'd10, 16'haaaa);
    send_transaction(OP_LOAD, 4'd3, 16'd100);
    send_transaction(OP_LOAD, 4'd7, 16'd100);
    send_transaction(OP_ALLOC, 4'd0, 16'hffff);
    send_transaction(OP_ALLOC, 4'd0, 16'haaaa);
    send_transaction(OP_ALLOC, 4'd0, 16'd100);
    send_transaction(OP_ALLOC, 4'd0, 16'd0);
    send_transaction(OP_ALLOC, 4'd0, 16'h8001);
    send_transaction(OP_LOAD, 4'd15, 16'hffff);
    send_transaction(OP_ALLOC, 4'd0, 16'd1);
    send_transaction(OP_ALLOC, 4'd0, 16'h7fff);
    send_transaction(OP_LOAD, 4'd0, 16'd0);
    random_transactions(150);

    for (int p = 0; p < 12; p++) begin
      if (p >= 10) begin
        reconfigure(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)));
      end else begin
        reconfigure(policies[p], counts[p]);
      end
      random_transactions(150);
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS fixed_partition_fit_allocator");
    end else begin
      $display("FAIL fixed_partition_fit_allocator");
    end
    $finish;
  end

endmodule
